// ===== sv/psa_pkg.sv =====
package psa_pkg;

    localparam int POOL_SIZE = 32;
    localparam int SLOT_W    = $clog2(POOL_SIZE);
    localparam int LINK_W    = $clog2(POOL_SIZE + 1);

    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(POOL_SIZE);

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_REJECTED   = 2'd1,
        ST_EMPTY      = 2'd2,
        ST_NOT_ACTIVE = 2'd3
    } t_status;

    typedef struct packed {
        logic              operation;
        logic [4:0]        slot_number;
        logic              expression_ok;
    } t_in_item;

    typedef struct packed {
        t_status           status;
        logic [4:0]        granted_slot;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_CHECK,
        S_UNLINK,
        S_PUSH,
        S_DONE
    } t_state;

    typedef enum logic {
        RD_FREE,
        RD_CUR
    } t_rd_sel;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    step;
        logic    hold;
        logic    alloc;
        logic    unlink;
        logic    push;
        logic    res_en;
        t_status res_status;
        logic    res_grant;
        logic    out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic ok;
        logic free_empty;
        logic walk_end;
        logic walk_match;
    } t_dp_sts;

endpackage

// ===== sv/psa_dp.sv =====
module psa_dp
    import psa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_data,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    output t_out_item o_out_data
);

    logic [LINK_W-1:0] r_link_mem [POOL_SIZE];
    logic [POOL_SIZE-1:0] r_vld;
    logic [LINK_W-1:0] r_rd_data;

    logic [LINK_W-1:0] r_active_head;
    logic [LINK_W-1:0] r_free_head;
    logic [LINK_W-1:0] r_cur;
    logic [LINK_W-1:0] r_prev;
    logic [LINK_W-1:0] r_steps;
    logic              r_use_rd;
    logic [4:0]        r_num;
    logic              r_ok;
    t_out_item         r_res;
    t_out_item         r_out;

    logic [LINK_W-1:0] rd_link;
    logic [LINK_W-1:0] cur_eff;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [LINK_W-1:0] wr_data;

    function automatic logic [LINK_W-1:0] clamp_link(input logic [LINK_W-1:0] l);
        return (l >= NIL_LINK) ? NIL_LINK : l;
    endfunction

    assign rd_link = clamp_link(r_rd_data);
    assign cur_eff = r_use_rd ? rd_link : r_cur;

    assign o_sts.ok         = r_ok;
    assign o_sts.free_empty = (r_free_head >= NIL_LINK);
    assign o_sts.walk_end   = (cur_eff >= NIL_LINK) || (r_steps == LINK_W'(POOL_SIZE));
    assign o_sts.walk_match = (cur_eff == LINK_W'(r_num));

    assign o_out_data = r_out;

    always_comb begin
        rd_addr = (i_cmd.rd_sel == RD_CUR) ? cur_eff[SLOT_W-1:0] : r_free_head[SLOT_W-1:0];
        wr_en   = 1'b0;
        wr_addr = r_free_head[SLOT_W-1:0];
        wr_data = r_active_head;
        if (i_cmd.alloc) begin
            wr_en   = 1'b1;
            wr_addr = r_free_head[SLOT_W-1:0];
            wr_data = r_active_head;
        end else if (i_cmd.unlink) begin
            wr_en   = (r_prev != NIL_LINK);
            wr_addr = r_prev[SLOT_W-1:0];
            wr_data = rd_link;
        end else if (i_cmd.push) begin
            wr_en   = 1'b1;
            wr_addr = r_cur[SLOT_W-1:0];
            wr_data = r_free_head;
        end
    end

    // link memory; an entry never written reads as its reset link
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_link_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_vld[rd_addr] ? r_link_mem[rd_addr] : LINK_W'(rd_addr) + LINK_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld         <= '0;
            r_active_head <= NIL_LINK;
            r_free_head   <= '0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (i_cmd.alloc) begin
                r_active_head <= r_free_head;
                r_free_head   <= rd_link;
            end
            if (i_cmd.unlink && (r_prev == NIL_LINK)) begin
                r_active_head <= rd_link;
            end
            if (i_cmd.push) begin
                r_free_head <= r_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num    <= i_in_data.slot_number;
            r_ok     <= i_in_data.expression_ok;
            r_cur    <= r_active_head;
            r_prev   <= NIL_LINK;
            r_steps  <= '0;
            r_use_rd <= 1'b0;
        end
        if (i_cmd.step) begin
            r_prev   <= cur_eff;
            r_steps  <= r_steps + LINK_W'(1);
            r_use_rd <= 1'b1;
        end
        if (i_cmd.hold) begin
            r_cur    <= cur_eff;
            r_use_rd <= 1'b0;
        end
        if (i_cmd.res_en) begin
            r_res.status       <= i_cmd.res_status;
            r_res.granted_slot <= i_cmd.res_grant ? 5'(r_free_head[SLOT_W-1:0]) : 5'd0;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

endmodule

// ===== sv/psa_ctrl.sv =====
module psa_ctrl
    import psa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_op,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load   = 1'b1;
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_FREE;
                    n_state      = (t_op'(i_op) == OP_RELEASE) ? S_CHECK : S_ALLOC;
                end
            end
            S_ALLOC: begin
                o_cmd.res_en = 1'b1;
                if (!i_sts.ok) begin
                    o_cmd.res_status = ST_REJECTED;
                end else if (i_sts.free_empty) begin
                    o_cmd.res_status = ST_EMPTY;
                end else begin
                    o_cmd.alloc      = 1'b1;
                    o_cmd.res_status = ST_OK;
                    o_cmd.res_grant  = 1'b1;
                end
                n_state = S_DONE;
            end
            S_CHECK: begin
                if (i_sts.walk_end) begin
                    o_cmd.res_en     = 1'b1;
                    o_cmd.res_status = ST_NOT_ACTIVE;
                    n_state          = S_DONE;
                end else if (i_sts.walk_match) begin
                    o_cmd.hold   = 1'b1;
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_CUR;
                    n_state      = S_UNLINK;
                end else begin
                    o_cmd.step   = 1'b1;
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_CUR;
                end
            end
            S_UNLINK: begin
                o_cmd.unlink = 1'b1;
                n_state      = S_PUSH;
            end
            S_PUSH: begin
                o_cmd.push       = 1'b1;
                o_cmd.res_en     = 1'b1;
                o_cmd.res_status = ST_OK;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/pooled_slot_allocator_unit.sv =====
// Pooled slot allocator: keeps POOL_SIZE numbered slots on a last-in first-out
// free list and an active list, both chained through one link memory. Each
// input item gives exactly one result item. An allocate steps through accept
// and read the free head's link, allocate, then hand the result to the output
// register. A release walks the active list one link per cycle through the
// link memory's registered read port: accept, up to POOL_SIZE link checks,
// unlink, push onto the free list, result. A miss ends after its last check,
// with no unlink or push. The result step waits while the output register
// still holds a stalled result. One item is worked at a time; the input
// stalls until the current item has left for the output register, which
// holds a finished result while the next item is accepted. After reset the
// link memory reads as its reset chain at once; no clearing pass is needed.
module pooled_slot_allocator_unit
    import psa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequence each item: accept, walk or allocate, write back, hand off
    psa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_in_data.operation),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (dp_cmd)
    );

    // hold list heads, link memory, walk pointers and the result registers
    psa_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .o_out_data (o_out_data)
    );

endmodule
